[hdl/sti_pkg.sv]
// sti_pkg: shared types and widths for the segment/triangle intersection pipeline
// depends on nothing
package sti_pkg;
  localparam int FIELD_BITS = 48;
  typedef struct packed {
    logic ok;
  } sti_flags_t;
endpackage

[hdl/sti_geom.sv]
// sti_geom: vector front end, normal, dot products and barycentric bound tests
// depends on sti_pkg
module sti_geom #(
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [sti_pkg::FIELD_BITS-1:0] seg_start,
  input  logic [sti_pkg::FIELD_BITS-1:0] seg_stop,
  input  logic [sti_pkg::FIELD_BITS-1:0] vertex_a,
  input  logic [sti_pkg::FIELD_BITS-1:0] vertex_b,
  input  logic [sti_pkg::FIELD_BITS-1:0] vertex_c,
  output logic out_valid,
  output sti_pkg::sti_flags_t out_flags,
  output logic [4*COORD_BITS+7:0] out_num,
  output logic [4*COORD_BITS+7:0] out_den
);
  import sti_pkg::*;
  localparam int DW = COORD_BITS + 1;       // differences
  localparam int CW = 2 * DW + 1;           // cross products
  localparam int PW = CW + DW;              // single products
  localparam int SW = PW + 2;               // dot sums
  localparam int OW = 4 * COORD_BITS + 8;

  function automatic logic signed [DW-1:0] slot(input logic [FIELD_BITS-1:0] w, input int s);
    logic signed [COORD_BITS-1:0] v;
    v = w[s*COORD_BITS +: COORD_BITS];
    return DW'(v);
  endfunction

  // stage 1: edge and segment differences
  logic v1;
  logic signed [DW-1:0] ab [3];
  logic signed [DW-1:0] ac [3];
  logic signed [DW-1:0] qp [3];
  logic signed [DW-1:0] ap [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ab[i] <= slot(vertex_b, i) - slot(vertex_a, i);
      ac[i] <= slot(vertex_c, i) - slot(vertex_a, i);
      qp[i] <= slot(seg_start, i) - slot(seg_stop, i);
      ap[i] <= slot(seg_start, i) - slot(vertex_a, i);
    end
  end

  // stage 2: cross product partial products
  logic v2;
  logic signed [2*DW-1:0] pn [6];
  logic signed [2*DW-1:0] pe [6];
  logic signed [DW-1:0] ab2 [3];
  logic signed [DW-1:0] ac2 [3];
  logic signed [DW-1:0] qp2 [3];
  logic signed [DW-1:0] ap2 [3];
  always_ff @(posedge clk) begin
    pn[0] <= ab[1] * ac[2]; pn[1] <= ab[2] * ac[1];
    pn[2] <= ab[2] * ac[0]; pn[3] <= ab[0] * ac[2];
    pn[4] <= ab[0] * ac[1]; pn[5] <= ab[1] * ac[0];
    pe[0] <= qp[1] * ap[2]; pe[1] <= qp[2] * ap[1];
    pe[2] <= qp[2] * ap[0]; pe[3] <= qp[0] * ap[2];
    pe[4] <= qp[0] * ap[1]; pe[5] <= qp[1] * ap[0];
    ab2 <= ab; ac2 <= ac; qp2 <= qp; ap2 <= ap;
  end

  // stage 3: cross product differences
  logic v3;
  logic signed [CW-1:0] n3 [3];
  logic signed [CW-1:0] e3 [3];
  logic signed [DW-1:0] ab3 [3];
  logic signed [DW-1:0] ac3 [3];
  logic signed [DW-1:0] qp3 [3];
  logic signed [DW-1:0] ap3 [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      n3[i] <= CW'(pn[2*i]) - CW'(pn[2*i+1]);
      e3[i] <= CW'(pe[2*i]) - CW'(pe[2*i+1]);
    end
    ab3 <= ab2; ac3 <= ac2; qp3 <= qp2; ap3 <= ap2;
  end

  // stage 4: dot product terms
  logic v4;
  logic signed [PW-1:0] td [3];
  logic signed [PW-1:0] tt [3];
  logic signed [PW-1:0] tv [3];
  logic signed [PW-1:0] tw [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      td[i] <= PW'(qp3[i]) * PW'(n3[i]);
      tt[i] <= PW'(ap3[i]) * PW'(n3[i]);
      tv[i] <= PW'(ac3[i]) * PW'(e3[i]);
      tw[i] <= PW'(ab3[i]) * PW'(e3[i]);
    end
  end

  // stage 5: dot sums
  logic v5;
  logic signed [SW-1:0] d5, t5, vv5, w5;
  always_ff @(posedge clk) begin
    d5  <= SW'(td[0]) + SW'(td[1]) + SW'(td[2]);
    t5  <= SW'(tt[0]) + SW'(tt[1]) + SW'(tt[2]);
    vv5 <= SW'(tv[0]) + SW'(tv[1]) + SW'(tv[2]);
    w5  <= -(SW'(tw[0]) + SW'(tw[1]) + SW'(tw[2]));
  end

  // stage 6: bound tests
  logic signed [SW:0] vw;
  logic ok;
  always_comb begin
    vw = (SW+1)'(vv5) + (SW+1)'(w5);
    ok = (d5 > 0) && (t5 >= 0) && (t5 <= d5) && (vv5 >= 0) && (vv5 <= d5)
      && (w5 >= 0) && (vw <= (SW+1)'(d5));
  end
  always_ff @(posedge clk) begin
    out_flags.ok <= ok;
    out_num <= OW'(unsigned'(t5));
    out_den <= OW'(unsigned'(d5));
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; out_valid <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; out_valid <= v5;
    end
  end
endmodule

[hdl/sti_div.sv]
// sti_div: pipelined restoring divider, one quotient bit per stage
// depends on sti_pkg
module sti_div #(
  parameter int COORD_BITS = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  sti_pkg::sti_flags_t in_flags,
  input  logic [4*COORD_BITS+7:0] in_num,
  input  logic [4*COORD_BITS+7:0] in_den,
  output logic out_valid,
  output logic hit_out,
  output logic [FRACTION_BITS:0] frac_out
);
  import sti_pkg::*;
  localparam int OW = 4 * COORD_BITS + 8;
  localparam int NS = FRACTION_BITS + 1;

  logic              vld [NS];
  logic              okp [NS];
  logic              full [NS];
  logic [OW:0]       rem [NS];
  logic [OW-1:0]     den [NS];
  logic [FRACTION_BITS-1:0] quo [NS];

  // stage 0: capture, full-scale case when numerator reaches denominator
  always_ff @(posedge clk) begin
    okp[0]  <= in_flags.ok;
    full[0] <= in_num >= in_den;
    rem[0]  <= (OW+1)'(in_num);
    den[0]  <= in_den;
    quo[0]  <= '0;
  end

  // one quotient bit per stage
  for (genvar s = 1; s < NS; s++) begin : g_bit
    logic [OW+1:0] sh;
    logic take;
    always_comb begin
      sh = {rem[s-1], 1'b0};
      take = sh >= (OW+2)'(den[s-1]);
    end
    always_ff @(posedge clk) begin
      okp[s]  <= okp[s-1];
      full[s] <= full[s-1];
      den[s]  <= den[s-1];
      rem[s]  <= take ? (OW+1)'(sh - (OW+2)'(den[s-1])) : (OW+1)'(sh);
      quo[s]  <= {quo[s-1][FRACTION_BITS-2:0], take};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    hit_out <= okp[NS-1];
    if (!okp[NS-1]) frac_out <= '0;
    else if (full[NS-1]) frac_out <= (FRACTION_BITS+1)'(1) << FRACTION_BITS;
    else frac_out <= {1'b0, quo[NS-1]};
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) vld[i] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i < NS; i++) vld[i] <= vld[i-1];
      out_valid <= vld[NS-1];
    end
  end
endmodule

[hdl/segment_triangle_intersection.sv]
// segment_triangle_intersection: top level, geometry pipeline then fraction divider
// one request accepted per cycle
// busy is always low; results appear with done for one cycle and cannot be stalled
// rst is synchronous and clears only the valid chain
// depends on sti_pkg, sti_geom, sti_div
module segment_triangle_intersection #(
  parameter int COORD_BITS = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [sti_pkg::FIELD_BITS-1:0] seg_start,
  input  logic [sti_pkg::FIELD_BITS-1:0] seg_stop,
  input  logic [sti_pkg::FIELD_BITS-1:0] vertex_a,
  input  logic [sti_pkg::FIELD_BITS-1:0] vertex_b,
  input  logic [sti_pkg::FIELD_BITS-1:0] vertex_c,
  output logic done,
  output logic hit,
  output logic [FRACTION_BITS:0] hit_fraction
);
  import sti_pkg::*;
  logic gv;
  sti_flags_t gf;
  logic [4*COORD_BITS+7:0] gn, gd;

  assign busy = 1'b0;

  // geometry and bound tests
  sti_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk, .rst, .in_valid(start), .seg_start, .seg_stop, .vertex_a, .vertex_b,
    .vertex_c, .out_valid(gv), .out_flags(gf), .out_num(gn), .out_den(gd)
  );

  // fraction division
  sti_div #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk, .rst, .in_valid(gv), .in_flags(gf), .in_num(gn), .in_den(gd),
    .out_valid(done), .hit_out(hit), .frac_out(hit_fraction)
  );
endmodule
